// ===== rtl/core/b64_pkg.sv =====
package b64_pkg;

  localparam int unsigned MaxResults = 3;
  localparam logic [7:0]  PadChar    = 8'h3D;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } b64_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       out_last;
    logic       bad_char;
  } b64_out_t;

  // One accepted input item, already worked out into its results.
  typedef struct packed {
    logic [1:0]                num;
    b64_out_t [MaxResults-1:0] res;
  } b64_job_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Character to 6-bit value; bit 6 set flags a character outside the alphabet
  function automatic logic [6:0] dec_value(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end else begin
      r = 7'd64;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/b64_front.sv =====
module b64_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b64_pkg::b64_in_t   in_data_i,
  input  logic               q_full_i,
  output logic               push_o,
  output b64_pkg::b64_job_t  job_o
);

  logic        mode_q;
  logic [11:0] buf_q, buf_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        pad_q, pad_d;
  logic        accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    logic [3:0]  bc;
    logic [3:0]  t;
    logic [3:0]  t2;
    logic [11:0] w;
    logic [11:0] rem;
    logic [5:0]  idx;
    logic [6:0]  v;
    logic [1:0]  n;
    b64_pkg::b64_out_t [b64_pkg::MaxResults-1:0] res;

    bc    = '0;
    t     = '0;
    t2    = '0;
    w     = '0;
    rem   = '0;
    idx   = '0;
    v     = '0;
    n     = '0;
    res   = '0;
    buf_d = buf_q;
    cnt_d = cnt_q;
    pad_d = pad_q;

    if (!mode_q) begin
      // encode: append the byte, take one or two sextets off the top
      bc  = (cnt_q > 4'd4) ? 4'd4 : cnt_q;
      t   = bc + 4'd8;
      w   = {buf_q[3:0], in_data_i.in_byte} & ~(12'hFFF << t);
      idx = 6'(w >> (t - 4'd6));
      res[0] = '{out_byte: b64_pkg::enc_char(idx), has_data: 1'b1,
                 out_last: 1'b0, bad_char: 1'b0};
      n  = 2'd1;
      t2 = t - 4'd6;
      if (t2 == 4'd6) begin
        res[1] = '{out_byte: b64_pkg::enc_char(w[5:0]), has_data: 1'b1,
                   out_last: 1'b0, bad_char: 1'b0};
        n  = 2'd2;
        t2 = 4'd0;
      end
      rem   = w & ~(12'hFFF << t2);
      buf_d = rem;
      cnt_d = t2;
      if (in_data_i.in_last) begin
        // flush leftover bits left-aligned
        if (t2 != 4'd0) begin
          idx    = 6'(rem << (4'd6 - t2));
          res[n] = '{out_byte: b64_pkg::enc_char(idx), has_data: 1'b1,
                     out_last: 1'b0, bad_char: 1'b0};
          n      = n + 2'd1;
        end
      end
    end else begin
      // decode: append a sextet, take a byte off the top once eight bits wait
      pad_d = pad_q | (in_data_i.in_byte == b64_pkg::PadChar);
      if (!pad_d) begin
        v = b64_pkg::dec_value(in_data_i.in_byte);
        if (v[6]) begin
          res[0] = '{out_byte: 8'd0, has_data: 1'b0, out_last: 1'b0, bad_char: 1'b1};
          n      = 2'd1;
        end else begin
          bc = (cnt_q > 4'd6) ? 4'd6 : cnt_q;
          t  = bc + 4'd6;
          w  = {buf_q[5:0], v[5:0]} & ~(12'hFFF << t);
          if (t >= 4'd8) begin
            res[0] = '{out_byte: 8'(w >> (t - 4'd8)), has_data: 1'b1,
                       out_last: 1'b0, bad_char: 1'b0};
            n = 2'd1;
            t = t - 4'd8;
          end
          buf_d = w & ~(12'hFFF << t);
          cnt_d = t;
        end
      end
      if (in_data_i.in_last && n == 2'd0) begin
        // bare end-of-message marker
        res[0] = '{out_byte: 8'd0, has_data: 1'b0, out_last: 1'b0, bad_char: 1'b0};
        n      = 2'd1;
      end
    end

    if (in_data_i.in_last) begin
      unique case (n)
        2'd1:    res[0].out_last = 1'b1;
        2'd2:    res[1].out_last = 1'b1;
        2'd3:    res[2].out_last = 1'b1;
        default: ;
      endcase
      buf_d = '0;
      cnt_d = '0;
      pad_d = 1'b0;
    end

    job_o.num = n;
    job_o.res = res;
    push_o    = accept & (n != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      buf_q  <= '0;
      cnt_q  <= '0;
      pad_q  <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
      buf_q  <= '0;
      cnt_q  <= '0;
      pad_q  <= 1'b0;
    end else if (accept) begin
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      pad_q  <= pad_d;
    end
  end

endmodule

// ===== rtl/core/b64_fifo.sv =====
module b64_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64_pkg::b64_job_t  job_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output b64_pkg::b64_job_t  head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64_pkg::b64_job_t mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/b64_back.sv =====
module b64_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  b64_pkg::b64_job_t  head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output b64_pkg::b64_out_t  out_data_o
);

  logic              valid_q, valid_d;
  b64_pkg::b64_out_t data_q, data_d;
  logic [1:0]        sel_q, sel_d;
  logic              load;

  assign load = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    sel_d   = sel_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = ~empty_i;
      if (!empty_i) begin
        unique case (sel_q)
          2'd0:    data_d = head_i.res[0];
          2'd1:    data_d = head_i.res[1];
          2'd2:    data_d = head_i.res[2];
          default: data_d = head_i.res[0];
        endcase
        // advance to the next job after its final result
        if (sel_q == head_i.num - 2'd1) begin
          pop_o = 1'b1;
          sel_d = '0;
        end else begin
          sel_d = sel_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= '0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/core/base64_codec_core.sv =====
// Streaming Base64 codec. Write cfg_wdata_i through cfg_we_i to pick the
// direction (0 encode, 1 decode); a write also abandons any partial message.
// Encode turns raw bytes into alphabet characters without '=' padding and
// flushes leftover bits on the item marked last. Decode turns characters into
// bytes, ignores everything from '=' to the message end, and reports a
// character outside the alphabet as a result with bad_char set. The front end
// takes one input transaction per cycle while the job queue has room; the back
// end delivers one result per cycle from a registered output while out_ready_i
// is high. Results per item: one or two per encoded byte plus one for the end
// flush (about 1.33 on average), and at most one per decoded character, so a
// character that adds bits without completing a byte makes no result of its own.
// The queue of QueueDepth jobs absorbs stalls on either side.
module base64_codec_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b64_pkg::b64_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output b64_pkg::b64_out_t  out_data_o
);

  logic              push, full, pop, empty;
  b64_pkg::b64_job_t job, head;

  // Front: hold the bit buffer, classify each transaction into a job
  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (full),
    .push_o      (push),
    .job_o       (job)
  );

  // Queue between front and back
  b64_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  // Back: drain each job one result per cycle while out_ready_i is high
  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A bad character never carries data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_char |-> !out_data_o.has_data)
    else $error("bad_char result carries data");

  // A result without data and without error is only the end-of-message marker
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_data && !out_data_o.bad_char |-> out_data_o.out_last)
    else $error("empty result outside end of message");

  // Results without data have a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_data |-> out_data_o.out_byte == 8'd0)
    else $error("nonzero byte on result without data");

  // The front end takes transactions whenever the queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> full)
    else $error("input stalled with queue space left");

endmodule
